// ----- sv/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

    localparam int POS_W   = 11;
    localparam int COUNT_W = 11;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_CHECK   = 4'b0010,
        S_COMPARE = 4'b0100,
        S_DONE    = 4'b1000
    } t_state;

    typedef struct packed {
        logic write_entry;
        logic load_search;
        logic issue_probe;
        logic go_left;
        logic go_right;
        logic set_hit;
        logic set_miss;
        logic out_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic lo_le_hi;
        logic key_lt;
        logic key_gt;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- sv/sorted_table_binary_search_top.sv -----
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted table of signed words with write and binary search operations.
//
// Channel   Direction  Handshake                  Word
// in        input      i_in_valid / o_in_stall    i_operation, i_position, i_value
// out       output     o_out_valid / i_out_stall  o_found, o_match_position
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_entry_count
//
// A write word is written from the idle state, which it does not leave. A
// search probes the table in turn through the check state, which reads the
// table memory through its single registered read port, and the compare
// state; with 1024 entries a search probes at most eleven times.
// Reset is synchronous and active low; it clears the entry count and the
// control state but not the table. A stalled result stays in the output
// register while the next word is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int WORD_WIDTH  = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [stbs_pkg::COUNT_W-1:0]  i_cfg_entry_count,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  wire                           i_operation,
    input  wire  [stbs_pkg::POS_W-1:0]    i_position,
    input  wire  signed [WORD_WIDTH-1:0]  i_value,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output logic                          o_found,
    output logic [stbs_pkg::POS_W-1:0]    o_match_position
);

    stbs_pkg::t_ctrl_cmd  cmd;
    stbs_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_entry_count (i_cfg_entry_count),
        .i_position        (i_position),
        .i_value           (i_value),
        .i_out_stall       (i_out_stall),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_out_valid       (o_out_valid),
        .o_found           (o_found),
        .o_match_position  (o_match_position)
    );

endmodule

`default_nettype wire

// ----- sv/stbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller state machine that sequences writes and binary search probes.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    input  wire                   i_operation,
    input  stbs_pkg::t_dp_status  i_status,
    output logic                  o_in_stall,
    output stbs_pkg::t_ctrl_cmd   o_cmd
);

    stbs_pkg::t_state r_state;
    stbs_pkg::t_state n_state;
    logic             accept;

    assign o_in_stall = (r_state != stbs_pkg::S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            stbs_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_operation == stbs_pkg::OP_SEARCH) begin
                        o_cmd.load_search = 1'b1;
                        n_state           = stbs_pkg::S_CHECK;
                    end else begin
                        o_cmd.write_entry = 1'b1;
                    end
                end
            end
            stbs_pkg::S_CHECK: begin
                if (i_status.lo_le_hi) begin
                    o_cmd.issue_probe = 1'b1;
                    n_state           = stbs_pkg::S_COMPARE;
                end else begin
                    o_cmd.set_miss = 1'b1;
                    n_state        = stbs_pkg::S_DONE;
                end
            end
            stbs_pkg::S_COMPARE: begin
                if (i_status.key_lt) begin
                    o_cmd.go_left = 1'b1;
                    n_state       = stbs_pkg::S_CHECK;
                end else if (i_status.key_gt) begin
                    o_cmd.go_right = 1'b1;
                    n_state        = stbs_pkg::S_CHECK;
                end else begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = stbs_pkg::S_DONE;
                end
            end
            stbs_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = stbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- sv/stbs_datapath.sv -----
// ----------------------------------------------------------------------------
// stbs_datapath
// Table memory, search interval registers, key compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int WORD_WIDTH  = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    input  wire  [stbs_pkg::COUNT_W-1:0]    i_cfg_entry_count,
    input  wire  [stbs_pkg::POS_W-1:0]      i_position,
    input  wire  signed [WORD_WIDTH-1:0]    i_value,
    input  wire                             i_out_stall,
    input  stbs_pkg::t_ctrl_cmd             i_cmd,
    output stbs_pkg::t_dp_status            o_status,
    output logic                            o_out_valid,
    output logic                            o_found,
    output logic [stbs_pkg::POS_W-1:0]      o_match_position
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BASE_W = (ADDR_W > stbs_pkg::POS_W) ? ADDR_W : stbs_pkg::POS_W;
    localparam int CMP_W  = BASE_W + 2;

    logic signed [WORD_WIDTH-1:0] r_table [TABLE_DEPTH];
    logic signed [WORD_WIDTH-1:0] r_rdata;
    logic signed [WORD_WIDTH-1:0] r_key;

    logic [stbs_pkg::COUNT_W-1:0] r_entry_count;
    logic [CMP_W-1:0]             r_lo;
    logic [CMP_W-1:0]             r_hi;
    logic [CMP_W-1:0]             r_mid;
    logic [CMP_W-1:0]             n_lo;
    logic [CMP_W-1:0]             n_hi;
    logic [CMP_W-1:0]             n_mid;
    logic [CMP_W:0]               mid_sum;
    logic [CMP_W-1:0]             count_ext;
    logic [CMP_W-1:0]             depth_ext;
    logic [CMP_W-1:0]             pos_ext;
    logic [CMP_W-1:0]             wr_index;
    logic [CMP_W-1:0]             rd_index;
    logic                         wr_ok;

    logic                         r_found;
    logic [stbs_pkg::POS_W-1:0]   r_pos;
    logic                         r_out_valid;
    logic                         r_out_found;
    logic [stbs_pkg::POS_W-1:0]   r_out_pos;

    assign count_ext = {{(CMP_W-stbs_pkg::COUNT_W){1'b0}}, r_entry_count};
    assign depth_ext = CMP_W'(TABLE_DEPTH);
    assign pos_ext   = {{(CMP_W-stbs_pkg::POS_W){1'b0}}, i_position};
    assign wr_ok     = (pos_ext != '0) && (pos_ext <= depth_ext);
    assign wr_index  = pos_ext - CMP_W'(1);
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign n_mid     = mid_sum[CMP_W:1];
    assign rd_index  = n_mid - CMP_W'(1);

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.load_search) begin
            n_lo = CMP_W'(1);
            n_hi = (count_ext > depth_ext) ? depth_ext : count_ext;
        end else if (i_cmd.go_left) begin
            n_hi = r_mid - CMP_W'(1);
        end else if (i_cmd.go_right) begin
            n_lo = r_mid + CMP_W'(1);
        end
    end

    assign o_status.lo_le_hi = (r_lo <= r_hi);
    assign o_status.key_lt   = (r_key < r_rdata);
    assign o_status.key_gt   = (r_key > r_rdata);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry && wr_ok) begin
            r_table[wr_index[ADDR_W-1:0]] <= i_value;
        end
        if (i_cmd.issue_probe) begin
            r_rdata <= r_table[rd_index[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
        if (i_cmd.load_search) begin
            r_key <= i_value;
        end
        if (i_cmd.issue_probe) begin
            r_mid <= n_mid;
        end
        if (i_cmd.set_hit) begin
            r_found <= 1'b1;
            r_pos   <= r_mid[stbs_pkg::POS_W-1:0];
        end else if (i_cmd.set_miss) begin
            r_found <= 1'b0;
            r_pos   <= '0;
        end
        if (i_cmd.out_load) begin
            r_out_found <= r_found;
            r_out_pos   <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_entry_count <= i_cfg_entry_count;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_out_found;
    assign o_match_position = r_out_pos;

endmodule

`default_nettype wire

// ----- tb/sv/tb_stbs_score_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stbs_score_pkg
// Scoreboard for the sorted table binary search testbench. It keeps its own
// copy of the table and the entry count, predicts the outcome of every
// accepted search word and checks each result word against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
package tb_stbs_score_pkg;

    localparam int TABLE_DEPTH = 1024;

    typedef struct {
        logic                           found;
        logic [stbs_pkg::POS_W-1:0]     position;
    } t_lookup;

    class t_lookup_scoreboard;
        logic signed [31:0] entries [TABLE_DEPTH];
        bit                 filled [TABLE_DEPTH];
        int unsigned        entry_count = 0;
        t_lookup            pending_lookups [$];
        int                 errors = 0;
        int                 searches = 0;
        int                 hits = 0;
        int                 misses = 0;
        int                 writes = 0;
        int                 ignored = 0;

        function void set_count(int unsigned cnt);
            entry_count = cnt;
        endfunction

        function bit holds(int p, logic signed [31:0] v);
            return filled[p-1] && entries[p-1] == v;
        endfunction

        function int pending();
            return pending_lookups.size();
        endfunction

        function t_lookup predict_lookup(logic signed [31:0] key);
            t_lookup res;
            int      lo;
            int      hi;
            int      mid;
            res.found = 1'b0;
            res.position = '0;
            lo = 1;
            hi = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : entry_count;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (key < entries[mid-1]) begin
                    hi = mid - 1;
                end else if (key > entries[mid-1]) begin
                    lo = mid + 1;
                end else begin
                    res.found = 1'b1;
                    res.position = stbs_pkg::POS_W'(mid);
                    return res;
                end
            end
            return res;
        endfunction

        function void note_input(logic op, logic [stbs_pkg::POS_W-1:0] pos,
                                 logic signed [31:0] value);
            t_lookup res;
            if (op == stbs_pkg::OP_WRITE) begin
                if (pos >= 1 && pos <= TABLE_DEPTH) begin
                    entries[pos-1] = value;
                    filled[pos-1] = 1'b1;
                    writes++;
                end else begin
                    ignored++;
                end
            end else begin
                res = predict_lookup(value);
                pending_lookups.push_back(res);
                searches++;
                if (res.found) hits++;
                else misses++;
            end
        endfunction

        function void score_result(logic found, logic [stbs_pkg::POS_W-1:0] position);
            t_lookup want;
            if (pending_lookups.size() == 0) begin
                $display("%0t: result word found=%0d position=%0d with no search outstanding",
                         $time, found, position);
                errors++;
                return;
            end
            want = pending_lookups.pop_front();
            if (found !== want.found) begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, found);
                errors++;
            end
            if (position !== want.position) begin
                $display("%0t: match_position expected %0d actual %0d",
                         $time, want.position, position);
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_sorted_table_binary_search_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_table_binary_search_top
// Self-checking testbench for the sorted table binary search block.
//
// A short directed part covers the empty table, ignored write positions and
// the extreme words. The random part then runs many short phases: each sets
// an entry count, plans a table (sorted, with duplicates, or deliberately
// broken), writes every entry that a search will probe and then searches for
// present, neighboring and random keys. Both channels idle and stall at
// random, and the entry count is changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search_top;

    localparam int TABLE_DEPTH = tb_stbs_score_pkg::TABLE_DEPTH;
    localparam int POS_W       = stbs_pkg::POS_W;
    localparam int COUNT_W     = stbs_pkg::COUNT_W;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam int RANDOM_ITEMS = 1050;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [COUNT_W-1:0]       i_cfg_entry_count = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic                     i_operation = 1'b0;
    logic [POS_W-1:0]         i_position = '0;
    logic signed [31:0]       i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_found;
    logic [POS_W-1:0]         o_match_position;

    tb_stbs_score_pkg::t_lookup_scoreboard sb = new();

    logic signed [31:0] plan [1:TABLE_DEPTH];
    longint             rise [1:TABLE_DEPTH];
    bit                 calm_in = 1'b0;
    int                 random_items = 0;
    int                 settings = 0;
    int                 seq_no = 0;
    int                 stall_left = 0;
    int                 quiet_left = 0;

    sorted_table_binary_search_top #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .WORD_WIDTH(32)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_entry_count(i_cfg_entry_count),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_operation(i_operation),
        .i_position(i_position),
        .i_value(i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_found(o_found),
        .o_match_position(o_match_position)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(negedge i_clk) begin
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 399) == 0) quiet_left = $urandom_range(50, 300);
        if (stall_left > 0) stall_left--;
        else if (quiet_left == 0) stall_left = pick_gap();
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.score_result(o_found, o_match_position);
    end

    task automatic send_word(input logic op, input logic [POS_W-1:0] pos,
                             input logic signed [31:0] val);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_position <= pos;
        i_value <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(op, pos, val);
        gap = calm_in ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_count(input int cnt);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_entry_count <= COUNT_W'(cnt);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_count(cnt);
        settings++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] bad_position();
        return ($urandom_range(0, 1) == 0) ? POS_W'(0) : POS_W'($urandom_range(1025, 2047));
    endfunction

    // Sorted plan with random steps; sometimes all duplicates, sometimes
    // spanning the full word range, sometimes one entry out of order.
    task automatic build_plan(input int cap);
        longint total;
        longint maxinc;
        longint span;
        longint base;
        int     r;
        total = 0;
        r = $urandom_range(0, 9);
        if (r == 0) maxinc = 0;
        else if (r < 4) maxinc = 3;
        else if (r < 7) maxinc = 1000;
        else maxinc = (cap > 1) ? 64'hFFFF_FFFF / (cap - 1) : 64'hFFFF_FFFF;
        for (int p = 1; p <= cap; p++) begin
            if (p > 1) total += $urandom_range(0, 32'(maxinc));
            rise[p] = total;
        end
        span = 64'hFFFF_FFFF - total;
        r = $urandom_range(0, 7);
        if (r == 0) base = -64'sd2147483648;
        else if (r == 1) base = -64'sd2147483648 + span;
        else base = -64'sd2147483648 + longint'($urandom_range(0, 32'(span)));
        for (int p = 1; p <= cap; p++) plan[p] = 32'(base + rise[p]);
        if (cap >= 2 && $urandom_range(0, 7) == 0) plan[$urandom_range(1, cap)] = $urandom;
    endtask

    // Writes each planned entry that the search will probe, then searches.
    task automatic search_along(input logic signed [31:0] key, input int cap);
        int lo;
        int hi;
        int mid;
        lo = 1;
        hi = cap;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (!sb.holds(mid, plan[mid])) begin
                send_word(stbs_pkg::OP_WRITE, POS_W'(mid), plan[mid]);
                random_items++;
            end
            if (key < plan[mid]) hi = mid - 1;
            else if (key > plan[mid]) lo = mid + 1;
            else break;
        end
        send_word(stbs_pkg::OP_SEARCH, POS_W'($urandom_range(0, 2047)), key);
        random_items++;
    endtask

    task automatic run_sequence(input int cnt);
        int                 cap;
        int                 n;
        int                 p;
        int                 r;
        logic signed [31:0] key;
        cap = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
        build_plan(cap);
        write_count(cnt);
        n = $urandom_range(2, 10);
        repeat (n) begin
            r = $urandom_range(0, 19);
            p = (cap > 0) ? $urandom_range(1, cap) : 0;
            if (r >= 18) begin
                if (r == 18 || cap == TABLE_DEPTH) begin
                    send_word(stbs_pkg::OP_WRITE, bad_position(), $urandom);
                end else begin
                    send_word(stbs_pkg::OP_WRITE,
                              POS_W'($urandom_range(cap + 1, TABLE_DEPTH)), $urandom);
                    random_items++;
                end
            end else begin
                if (r == 16) key = KEY_MIN;
                else if (r == 17) key = KEY_MAX;
                else if (cap == 0 || r >= 14) key = $urandom;
                else if (r >= 11) key = plan[p] - 32'sd1;
                else if (r >= 8) key = plan[p] + 32'sd1;
                else key = plan[p];
                search_along(key, cap);
            end
        end
    endtask

    function automatic int pick_count(int seq);
        int r;
        case (seq)
            0: return TABLE_DEPTH;
            1: return 2047;
            2: return 0;
            3: return TABLE_DEPTH - 1;
            4: return TABLE_DEPTH + 1;
            default: begin
                r = $urandom_range(0, 19);
                if (r < 14) return $urandom_range(1, 16);
                if (r < 18) return $urandom_range(17, 128);
                if (r == 18) return 0;
                return $urandom_range(129, 2047);
            end
        endcase
    endfunction

    initial begin
        #10_000_000;
        $display("tb_sorted_table_binary_search_top: errors");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The entry count is zero after reset, so every search misses.
        send_word(stbs_pkg::OP_SEARCH, '0, 32'sd0);
        send_word(stbs_pkg::OP_SEARCH, POS_W'(2047), KEY_MIN);
        send_word(stbs_pkg::OP_SEARCH, POS_W'(1), KEY_MAX);
        send_word(stbs_pkg::OP_WRITE, POS_W'(0), 32'sh5A5A_5A5A);
        send_word(stbs_pkg::OP_WRITE, POS_W'(2047), 32'shA5A5_A5A5);
        send_word(stbs_pkg::OP_WRITE, POS_W'(1025), -32'sd7);
        send_word(stbs_pkg::OP_WRITE, POS_W'(1), KEY_MIN);
        send_word(stbs_pkg::OP_WRITE, POS_W'(2), -32'sd1);
        send_word(stbs_pkg::OP_WRITE, POS_W'(3), 32'sd0);
        send_word(stbs_pkg::OP_WRITE, POS_W'(4), KEY_MAX);
        send_word(stbs_pkg::OP_WRITE, POS_W'(1024), 32'sd5);
        write_count(4);
        send_word(stbs_pkg::OP_SEARCH, '0, KEY_MIN);
        send_word(stbs_pkg::OP_SEARCH, '0, -32'sd1);
        send_word(stbs_pkg::OP_SEARCH, '0, 32'sd0);
        send_word(stbs_pkg::OP_SEARCH, '0, KEY_MAX);
        send_word(stbs_pkg::OP_SEARCH, '0, 32'sd1);
        send_word(stbs_pkg::OP_SEARCH, '0, -32'sd2);
        write_count(1);
        send_word(stbs_pkg::OP_SEARCH, '0, KEY_MIN);
        send_word(stbs_pkg::OP_SEARCH, '0, 32'sd0);

        while (random_items < RANDOM_ITEMS) begin
            calm_in = ($urandom_range(0, 5) == 0);
            run_sequence(pick_count(seq_no));
            seq_no++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Run covered %0d searches (%0d hits, %0d misses), %0d table writes and %0d",
                 sb.searches, sb.hits, sb.misses, sb.writes, sb.ignored);
        $display("out-of-range writes over %0d entry count settings between 0 and 2047.",
                 settings);
        if (sb.errors == 0) begin
            $display("tb_sorted_table_binary_search_top: clean");
        end else begin
            $display("tb_sorted_table_binary_search_top: errors");
        end
        $finish;
    end

endmodule
